FILE: rtl/dgpi_pkg.sv
`timescale 1ns / 1ps
// Package for the double gate pulse integrator.
// Register map codes, field widths, reset values and the register struct.
// No dependencies.
package dgpi_pkg;

  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_AW   = 5;
  localparam int TRIG_W   = 12;
  localparam int CFG_W    = 13;
  localparam int SCALE_W  = 16;
  localparam int CUT_W    = 32;
  localparam int CHARGE_W = 16;

  localparam logic [CHARGE_W-1:0] CHARGE_MAX = '1;

  typedef enum logic [2:0] {
    REG_BASELINE_LENGTH   = 3'd0,
    REG_SHORT_LEAD        = 3'd1,
    REG_LONG_LEAD         = 3'd2,
    REG_SHORT_WIDTH       = 3'd3,
    REG_LONG_WIDTH        = 3'd4,
    REG_POSITIVE_POLARITY = 3'd5,
    REG_CHARGE_SCALE      = 3'd6,
    REG_ENERGY_CUT        = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic        [CFG_W-1:0]   baseline_length;
    logic signed [CFG_W-1:0]   short_lead;
    logic signed [CFG_W-1:0]   long_lead;
    logic        [CFG_W-1:0]   short_width;
    logic        [CFG_W-1:0]   long_width;
    logic                      positive_polarity;
    logic        [SCALE_W-1:0] charge_scale;
    logic signed [CUT_W-1:0]   energy_cut;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    baseline_length:   CFG_W'(16),
    short_lead:        '0,
    long_lead:         '0,
    short_width:       '0,
    long_width:        '0,
    positive_polarity: 1'b0,
    charge_scale:      SCALE_W'(256),
    energy_cut:        '0
  };

endpackage

FILE: rtl/double_gate_pulse_integrator.sv
`timescale 1ns / 1ps
// Double gate pulse integrator: baseline, short and long gate charges, threshold.
// Uses dgpi_pkg for register codes, widths and reset values.
//
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_ready   in_sample, in_trigger_index, in_last_sample
// out      out  out_valid / out_ready short/long charge, baseline, selected, error
// apb      in   psel/penable/pwrite   registers 0..7 at byte address 4*i
//
// Samples are taken one per cycle while a waveform is accumulated.
// After the last sample the shared adder runs shift-add multiplies and a restoring
// divide for each charge and for the baseline; in_ready is low meanwhile.
// Reset is synchronous and clears control and waveform state.
// A result waiting on out_ready holds the output register; new samples still enter.
module double_gate_pulse_integrator
  import dgpi_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic [TRIG_W-1:0]      in_trigger_index,
  input  logic                   in_last_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CHARGE_W-1:0]    out_short_charge,
  output logic [CHARGE_W-1:0]    out_long_charge,
  output logic [CHARGE_W-1:0]    out_baseline_level,
  output logic                   out_selected,
  output logic                   out_setup_error,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_AW-1:0]      paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int IW  = $clog2(MAX_SAMPLES);
  localparam int SW  = SAMPLE_BITS + IW;
  localparam int GW  = (IW + 3 > 15) ? IW + 3 : 15;
  localparam int MX  = (IW + 1 > CFG_W) ? IW + 1 : CFG_W;
  localparam int W   = SW + MX + 19;
  localparam int MW  = (IW + 1 > SCALE_W) ? IW + 1 : SCALE_W;
  localparam int CW  = $clog2(MW);
  localparam logic [IW-1:0]        IDX_LAST = IW'(MAX_SAMPLES - 1);
  localparam logic signed [GW-1:0] G_ONE    = GW'(1);

  typedef enum logic [3:0] {
    S_ACC, S_G1LD, S_MUL1, S_MUL2, S_MUL3, S_CUT,
    S_XPREP, S_XADD, S_SAT, S_DIV, S_DIVEND, S_DONE
  } state_t;

  typedef enum logic [1:0] {PH_SHORT, PH_LONG, PH_BASE} phase_t;

  // configuration
  cfg_t cfg_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[CFG_AW-1:2]))
        REG_BASELINE_LENGTH:   cfg_r.baseline_length   <= pwdata[CFG_W-1:0];
        REG_SHORT_LEAD:        cfg_r.short_lead        <= pwdata[CFG_W-1:0];
        REG_LONG_LEAD:         cfg_r.long_lead         <= pwdata[CFG_W-1:0];
        REG_SHORT_WIDTH:       cfg_r.short_width       <= pwdata[CFG_W-1:0];
        REG_LONG_WIDTH:        cfg_r.long_width        <= pwdata[CFG_W-1:0];
        REG_POSITIVE_POLARITY: cfg_r.positive_polarity <= pwdata[0];
        REG_CHARGE_SCALE:      cfg_r.charge_scale      <= pwdata[SCALE_W-1:0];
        REG_ENERGY_CUT:        cfg_r.energy_cut        <= pwdata[CUT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[CFG_AW-1:2]))
      REG_BASELINE_LENGTH:   prdata = 32'(cfg_r.baseline_length);
      REG_SHORT_LEAD:        prdata = 32'(cfg_r.short_lead);
      REG_LONG_LEAD:         prdata = 32'(cfg_r.long_lead);
      REG_SHORT_WIDTH:       prdata = 32'(cfg_r.short_width);
      REG_LONG_WIDTH:        prdata = 32'(cfg_r.long_width);
      REG_POSITIVE_POLARITY: prdata = 32'(cfg_r.positive_polarity);
      REG_CHARGE_SCALE:      prdata = 32'(cfg_r.charge_scale);
      REG_ENERGY_CUT:        prdata = 32'(cfg_r.energy_cut);
    endcase
  end

  // gate start: trigger minus pregate, clamped at 0
  function automatic logic signed [GW-1:0] gate_s(input logic [TRIG_W-1:0] trig,
                                                 input logic signed [CFG_W-1:0] pre);
    logic signed [GW-1:0] s;
    s = $signed(GW'(trig)) - GW'(pre);
    if (s < 0) s = '0;
    return s;
  endfunction

  // gate end: start plus width minus one, clamped at 0
  function automatic logic signed [GW-1:0] gate_e(input logic signed [GW-1:0] s,
                                                 input logic [CFG_W-1:0] w);
    logic signed [GW-1:0] e;
    e = s + $signed(GW'(w)) - G_ONE;
    if (e < 0) e = '0;
    return e;
  endfunction

  // waveform state
  logic [IW-1:0]     idx_r;
  logic [SW-1:0]     run_r, prev_r, base_r;
  logic [SW-1:0]     so_r, sc_r, lo_r, lc_r;
  logic [TRIG_W-1:0] trig_r;

  // sequencer and shared adder
  state_t                 state_r;
  phase_t                 ph_r;
  logic signed [W-1:0]    acc_r, mcand_r, num_r;
  logic [MW-1:0]          mplier_r;
  logic [CW-1:0]          cnt_r;
  logic                   sub_r;
  logic [CHARGE_W-1:0]    quo_r;
  logic [CHARGE_W-1:0]    short_q_r, long_q_r, base_q_r;
  logic                   sel_r, err_r;

  logic                   out_valid_r, out_sel_r, out_err_r;
  logic [CHARGE_W-1:0]    out_short_r, out_long_r, out_base_r;

  logic signed [W-1:0]    sum, acc_step;
  logic [SW-1:0]          run_nxt;
  logic signed [GW-1:0]   idx_s, n_s, len_s;
  logic [TRIG_W-1:0]      trig_eff;
  logic signed [GW-1:0]   rs_s, rs_e, rl_s, rl_e;
  logic signed [CFG_W-1:0] g_pre;
  logic [CFG_W-1:0]       g_w;
  logic [SW-1:0]          g_open, g_close, g_o, g_c, g_diff;
  logic signed [GW-1:0]   g_s, g_e, g_cnt;
  logic                   accept, wave_end, bad_len, out_free;

  assign sum      = acc_r + (sub_r ? ~mcand_r : mcand_r) + W'(sub_r);
  assign acc_step = mplier_r[0] ? sum : acc_r;

  assign in_ready = (state_r == S_ACC);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign run_nxt  = run_r + SW'(in_sample);
  assign idx_s    = $signed(GW'(idx_r));
  assign n_s      = idx_s + G_ONE;
  assign len_s    = $signed(GW'(cfg_r.baseline_length));
  assign trig_eff = (idx_r == '0) ? in_trigger_index : trig_r;
  assign rs_s     = gate_s(trig_eff, cfg_r.short_lead);
  assign rs_e     = gate_e(rs_s, cfg_r.short_width);
  assign rl_s     = gate_s(trig_eff, cfg_r.long_lead);
  assign rl_e     = gate_e(rl_s, cfg_r.long_width);
  assign wave_end = in_last_sample || (idx_r == IDX_LAST);
  assign bad_len  = (cfg_r.baseline_length == '0) || (len_s > n_s);

  // gate bounds at the end of the waveform
  always_comb begin
    g_pre   = (ph_r == PH_LONG) ? cfg_r.long_lead  : cfg_r.short_lead;
    g_w     = (ph_r == PH_LONG) ? cfg_r.long_width : cfg_r.short_width;
    g_open  = (ph_r == PH_LONG) ? lo_r : so_r;
    g_close = (ph_r == PH_LONG) ? lc_r : sc_r;
    g_s     = gate_s(trig_r, g_pre);
    if (g_s >= n_s) begin
      g_s = n_s - G_ONE;
      g_o = (n_s >= GW'(2)) ? prev_r : '0;
      g_e = gate_e(g_s, g_w);
      if (g_e >= n_s) g_e = n_s - G_ONE;
      g_c = (g_e == n_s - G_ONE) ? run_r : prev_r;
    end else begin
      g_o = (g_s == '0) ? '0 : g_open;
      g_e = gate_e(g_s, g_w);
      if (g_e >= n_s - G_ONE) begin
        g_e = n_s - G_ONE;
        g_c = run_r;
      end else begin
        g_c = g_close;
      end
    end
    g_cnt  = g_e - g_s + G_ONE;
    g_diff = g_c - g_o;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      ph_r        <= PH_SHORT;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      run_r       <= '0;
      prev_r      <= '0;
      base_r      <= '0;
      so_r        <= '0;
      sc_r        <= '0;
      lo_r        <= '0;
      lc_r        <= '0;
      trig_r      <= '0;
      cnt_r       <= '0;
      sub_r       <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_ACC: begin
          if (accept) begin
            if (idx_r == '0) trig_r <= in_trigger_index;
            prev_r <= run_r;
            run_r  <= run_nxt;
            if (len_s == n_s) base_r <= run_nxt;
            if (rs_s >= G_ONE && idx_s == rs_s - G_ONE) so_r <= run_nxt;
            if (idx_s == rs_e) sc_r <= run_nxt;
            if (rl_s >= G_ONE && idx_s == rl_s - G_ONE) lo_r <= run_nxt;
            if (idx_s == rl_e) lc_r <= run_nxt;
            if (!wave_end) begin
              idx_r <= idx_r + IW'(1);
            end else if (bad_len) begin
              err_r     <= 1'b1;
              sel_r     <= 1'b0;
              short_q_r <= '0;
              long_q_r  <= '0;
              base_q_r  <= '0;
              state_r   <= S_DONE;
            end else begin
              err_r   <= 1'b0;
              ph_r    <= PH_SHORT;
              state_r <= S_G1LD;
            end
          end
        end
        S_G1LD: begin
          acc_r    <= '0;
          mcand_r  <= W'(g_diff);
          mplier_r <= MW'(cfg_r.baseline_length);
          sub_r    <= 1'b0;
          cnt_r    <= CW'(CFG_W - 1);
          state_r  <= S_MUL1;
        end
        S_MUL1, S_MUL2, S_MUL3, S_CUT: begin
          acc_r    <= acc_step;
          mcand_r  <= mcand_r <<< 1;
          mplier_r <= mplier_r >> 1;
          cnt_r    <= cnt_r - CW'(1);
          if (cnt_r == '0) begin
            priority case (state_r)
              S_MUL1: begin
                mcand_r  <= W'(base_r);
                mplier_r <= MW'(g_cnt[IW:0]);
                sub_r    <= 1'b1;
                cnt_r    <= CW'(IW);
                state_r  <= S_MUL2;
              end
              S_MUL2: begin
                acc_r    <= '0;
                mcand_r  <= acc_step;
                mplier_r <= MW'(cfg_r.charge_scale);
                sub_r    <= !cfg_r.positive_polarity;
                cnt_r    <= CW'(SCALE_W - 1);
                state_r  <= S_MUL3;
              end
              S_MUL3: begin
                num_r <= acc_step;
                if (ph_r == PH_LONG) begin
                  mcand_r  <= W'(cfg_r.energy_cut) <<< 8;
                  mplier_r <= MW'(cfg_r.baseline_length);
                  sub_r    <= 1'b1;
                  cnt_r    <= CW'(CFG_W - 1);
                  state_r  <= S_CUT;
                end else begin
                  state_r <= S_XPREP;
                end
              end
              default: begin
                sel_r   <= ~acc_step[W-1];
                state_r <= S_XPREP;
              end
            endcase
          end
        end
        S_XPREP: begin
          if (num_r[W-1] || num_r == '0) begin
            quo_r   <= '0;
            state_r <= S_DIVEND;
          end else begin
            acc_r   <= num_r <<< 1;
            mcand_r <= W'(cfg_r.baseline_length) <<< 8;
            sub_r   <= 1'b0;
            state_r <= S_XADD;
          end
        end
        S_XADD: begin
          // rounded quotient of (2x + d) / 2d, divisor set up shifted by 16
          acc_r   <= sum;
          mcand_r <= (ph_r == PH_BASE) ? (W'(cfg_r.baseline_length) <<< 17)
                                       : (W'(cfg_r.baseline_length) <<< 25);
          sub_r   <= 1'b1;
          state_r <= S_SAT;
        end
        S_SAT: begin
          if (!sum[W-1]) begin
            quo_r   <= CHARGE_MAX;
            state_r <= S_DIVEND;
          end else begin
            mcand_r <= mcand_r >>> 1;
            quo_r   <= '0;
            cnt_r   <= CW'(CHARGE_W - 1);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (!sum[W-1]) acc_r <= sum;
          quo_r   <= {quo_r[CHARGE_W-2:0], ~sum[W-1]};
          mcand_r <= mcand_r >>> 1;
          cnt_r   <= cnt_r - CW'(1);
          if (cnt_r == '0) state_r <= S_DIVEND;
        end
        S_DIVEND: begin
          unique case (ph_r)
            PH_SHORT: begin
              short_q_r <= quo_r;
              ph_r      <= PH_LONG;
              state_r   <= S_G1LD;
            end
            PH_LONG: begin
              long_q_r <= quo_r;
              ph_r     <= PH_BASE;
              acc_r    <= W'(base_r) <<< 1;
              mcand_r  <= W'(cfg_r.baseline_length);
              sub_r    <= 1'b0;
              state_r  <= S_XADD;
            end
            default: begin
              base_q_r <= quo_r;
              state_r  <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_short_r <= short_q_r;
            out_long_r  <= long_q_r;
            out_base_r  <= base_q_r;
            out_sel_r   <= sel_r;
            out_err_r   <= err_r;
            idx_r       <= '0;
            run_r       <= '0;
            prev_r      <= '0;
            base_r      <= '0;
            so_r        <= '0;
            sc_r        <= '0;
            lo_r        <= '0;
            lc_r        <= '0;
            trig_r      <= '0;
            state_r     <= S_ACC;
          end
        end
        default: state_r <= S_ACC;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_short_charge   = out_short_r;
  assign out_long_charge    = out_long_r;
  assign out_baseline_level = out_base_r;
  assign out_selected       = out_sel_r;
  assign out_setup_error    = out_err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_short_r == '0 && out_long_r == '0 &&
    out_base_r == '0 && !out_sel_r)
    else $error("setup error transaction carries nonzero fields");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_sample |=> !in_ready)
    else $error("sample taken right after end of waveform");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_free |=> out_valid_r && state_r == S_ACC)
    else $error("finished result not loaded");

  a_base_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SAT && ph_r == PH_BASE |-> sum[W-1])
    else $error("baseline quotient overflow");

endmodule
